[src/gvam_pkg.sv]
// ----------------------------------------------------------------------------
// gvam_pkg: shared types and constants of the graphics memory access mapper
// Payload structs, queue entry, operation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gvam_pkg;

  localparam int ADDR_W  = 21;
  localparam int MEM_AW  = 19;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int LINE_W  = 10;
  localparam int XLINE_W = 9;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int SCROLL_W = 10;
  localparam int MODE_W  = 4;

  localparam logic [LINE_W-1:0] NO_LINE = 10'd1023;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SCROLL0 = 3'd1;
  localparam logic [2:0] REG_SCROLL1 = 3'd2;
  localparam logic [2:0] REG_SCROLL2 = 3'd3;
  localparam logic [2:0] REG_SCROLL3 = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] bus_address;
    logic [7:0]        write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               dirty_valid;
    logic [LINE_W-1:0]  dirty_line;
    logic               extra_dirty_valid;
    logic [XLINE_W-1:0] extra_dirty_line;
  } out_t;

  // What the back end does with one item.
  typedef enum logic [2:0] {
    OP_RD_ZERO,
    OP_RD_BYTE,
    OP_RD_HI,
    OP_RD_LO,
    OP_WR_NONE,
    OP_WR_BYTE,
    OP_WR_HI,
    OP_WR_LO
  } op_e;

  typedef enum logic [2:0] {
    CT_WIDE16,
    CT_PAGE16,
    CT_256A,
    CT_256B,
    CT_64K
  } ctype_e;

  typedef struct packed {
    op_e                op;
    logic [MEM_AW-1:0]  idx;
    logic [7:0]         wdata;
    logic [LINE_W-1:0]  dirty_line;
    logic               extra_valid;
    logic [XLINE_W-1:0] extra_line;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

`default_nettype wire

[src/gvam_front.sv]
// ----------------------------------------------------------------------------
// gvam_front: register file and access classifier
// Holds the mode and scroll registers and turns each bus access into a
// queue entry with memory index, operation and dirty line numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module gvam_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gvam_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [gvam_pkg::PDATA_W-1:0]  pwdata,
  output logic      [gvam_pkg::PDATA_W-1:0]  prdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire gvam_pkg::in_t                 in_data,
  input  wire gvam_pkg::q_status_t           q_stat,
  input  wire gvam_pkg::bk_status_t          bk_stat,
  output logic                               q_push,
  output gvam_pkg::entry_t                   q_entry
);

  logic [gvam_pkg::MODE_W-1:0]   mode_r;
  logic [gvam_pkg::SCROLL_W-1:0] scroll0_r, scroll1_r, scroll2_r, scroll3_r;
  logic                          cfg_wr;
  logic [2:0]                    reg_idx;
  gvam_pkg::ctype_e              ctype;
  logic [gvam_pkg::ADDR_W-1:0]   a;
  logic [gvam_pkg::SCROLL_W-1:0] s_pg16;
  logic [gvam_pkg::SCROLL_W-1:0] s_even;
  logic [gvam_pkg::SCROLL_W-1:0] s_odd;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      scroll0_r <= '0;
      scroll1_r <= '0;
      scroll2_r <= '0;
      scroll3_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gvam_pkg::REG_MODE:    mode_r    <= pwdata[gvam_pkg::MODE_W-1:0];
        gvam_pkg::REG_SCROLL0: scroll0_r <= pwdata[gvam_pkg::SCROLL_W-1:0];
        gvam_pkg::REG_SCROLL1: scroll1_r <= pwdata[gvam_pkg::SCROLL_W-1:0];
        gvam_pkg::REG_SCROLL2: scroll2_r <= pwdata[gvam_pkg::SCROLL_W-1:0];
        gvam_pkg::REG_SCROLL3: scroll3_r <= pwdata[gvam_pkg::SCROLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      gvam_pkg::REG_MODE:    prdata = {28'b0, mode_r};
      gvam_pkg::REG_SCROLL0: prdata = {22'b0, scroll0_r};
      gvam_pkg::REG_SCROLL1: prdata = {22'b0, scroll1_r};
      gvam_pkg::REG_SCROLL2: prdata = {22'b0, scroll2_r};
      gvam_pkg::REG_SCROLL3: prdata = {22'b0, scroll3_r};
      default:               prdata = '0;
    endcase
  end

  // Colour type: bit 3 wins, then bit 2, then the two low bits.
  always_comb begin
    ctype = gvam_pkg::CT_PAGE16;
    if (mode_r[3]) begin
      ctype = gvam_pkg::CT_64K;
    end else if (mode_r[2]) begin
      ctype = gvam_pkg::CT_WIDE16;
    end else begin
      case (mode_r[1:0])
        2'd0:    ctype = gvam_pkg::CT_PAGE16;
        2'd1:    ctype = gvam_pkg::CT_256A;
        2'd2:    ctype = gvam_pkg::CT_256B;
        default: ctype = gvam_pkg::CT_64K;
      endcase
    end
  end

  assign in_stall = q_stat.full || bk_stat.clearing;
  assign q_push   = in_valid && !in_stall;
  assign a        = in_data.bus_address;

  // Scroll selection for the page that an address falls into.
  always_comb begin
    case (a[20:19])
      2'd0:    s_pg16 = scroll0_r;
      2'd1:    s_pg16 = scroll1_r;
      2'd2:    s_pg16 = scroll2_r;
      default: s_pg16 = scroll3_r;
    endcase
  end
  assign s_even = a[19] ? scroll2_r : scroll0_r;
  assign s_odd  = a[19] ? scroll3_r : scroll1_r;

  always_comb begin
    q_entry             = '0;
    q_entry.wdata       = in_data.write_byte;
    q_entry.op          = in_data.cmd ? gvam_pkg::OP_WR_NONE : gvam_pkg::OP_RD_ZERO;
    q_entry.dirty_line  = in_data.cmd ? gvam_pkg::NO_LINE : '0;
    q_entry.extra_valid = 1'b0;
    q_entry.extra_line  = '0;
    q_entry.idx         = a[18:0];
    case (ctype)
      gvam_pkg::CT_WIDE16: begin
        q_entry.idx = {a[19:11], a[9:0]} ^ {18'b0, ~a[20]};
        if (a[0]) begin
          if (in_data.cmd) begin
            q_entry.op         = a[10] ? gvam_pkg::OP_WR_HI : gvam_pkg::OP_WR_LO;
            q_entry.dirty_line = 10'(a[20:11] - scroll0_r);
          end else begin
            q_entry.op = a[10] ? gvam_pkg::OP_RD_HI : gvam_pkg::OP_RD_LO;
          end
        end
      end
      gvam_pkg::CT_PAGE16: begin
        q_entry.idx = a[18:0] ^ {18'b0, ~a[20]};
        if (a[0]) begin
          if (in_data.cmd) begin
            q_entry.op         = a[19] ? gvam_pkg::OP_WR_HI : gvam_pkg::OP_WR_LO;
            q_entry.dirty_line = {1'b0, 9'(a[18:10] - s_pg16[8:0])};
          end else begin
            q_entry.op = a[19] ? gvam_pkg::OP_RD_HI : gvam_pkg::OP_RD_LO;
          end
        end
      end
      gvam_pkg::CT_256A, gvam_pkg::CT_256B: begin
        q_entry.idx = a[18:0] ^ {18'b0, ~a[19]};
        if (a[0] && !a[20]) begin
          if (in_data.cmd) begin
            q_entry.op          = gvam_pkg::OP_WR_BYTE;
            q_entry.extra_valid = 1'b1;
            q_entry.extra_line  = 9'(a[18:10] - s_even[8:0]);
            q_entry.dirty_line  = {1'b0, 9'(a[18:10] - s_odd[8:0])};
          end else begin
            q_entry.op = gvam_pkg::OP_RD_BYTE;
          end
        end
      end
      default: begin
        q_entry.idx = a[18:0] ^ 19'd1;
        if (a[20:19] == 2'd0) begin
          if (in_data.cmd) begin
            q_entry.op         = gvam_pkg::OP_WR_BYTE;
            q_entry.dirty_line = {1'b0, 9'(a[18:10] - scroll0_r[8:0])};
          end else begin
            q_entry.op = gvam_pkg::OP_RD_BYTE;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[src/gvam_queue.sv]
// ----------------------------------------------------------------------------
// gvam_queue: two-entry queue between classifier and memory engine
// Plain flip-flop FIFO; either side may stall without holding the other.
// ----------------------------------------------------------------------------
`default_nettype none

module gvam_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gvam_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output gvam_pkg::entry_t       head,
  output gvam_pkg::q_status_t    stat
);

  gvam_pkg::entry_t ent_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

endmodule

`default_nettype wire

[src/gvam_back.sv]
// ----------------------------------------------------------------------------
// gvam_back: memory engine with the 512 KB pixel store
// Clears the store after reset, then runs each queued access as a
// read followed by an optional merged write, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gvam_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gvam_pkg::entry_t   head,
  input  wire gvam_pkg::q_status_t q_stat,
  output logic                    pop,
  output gvam_pkg::bk_status_t    stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gvam_pkg::out_t          out_data
);

  typedef enum logic [2:0] {
    BK_CLEAR = 3'b001,
    BK_IDLE  = 3'b010,
    BK_EXEC  = 3'b100
  } bk_state_t;

  logic [7:0]                  mem [gvam_pkg::MEM_DEPTH];
  bk_state_t                   state_r, state_nxt;
  logic [gvam_pkg::MEM_AW-1:0] clr_idx_r;
  gvam_pkg::entry_t            ex_r;
  logic [7:0]                  rdata_r;
  logic                        out_valid_r;
  gvam_pkg::out_t              out_data_r;
  gvam_pkg::out_t              res;
  logic                        finish;
  logic                        store;
  logic [7:0]                  merged;
  logic                        mem_we;
  logic [gvam_pkg::MEM_AW-1:0] mem_waddr;
  logic [7:0]                  mem_wdata;

  assign pop    = (state_r == BK_IDLE) && !q_stat.empty;
  assign finish = (state_r == BK_EXEC) && (!out_valid_r || !out_stall);

  // Result and merged byte for the item in flight.
  always_comb begin
    res    = '0;
    store  = 1'b0;
    merged = rdata_r;
    res.dirty_line        = ex_r.dirty_line;
    res.extra_dirty_valid = ex_r.extra_valid;
    res.extra_dirty_line  = ex_r.extra_line;
    case (ex_r.op)
      gvam_pkg::OP_RD_ZERO: res.read_byte = '0;
      gvam_pkg::OP_RD_BYTE: res.read_byte = rdata_r;
      gvam_pkg::OP_RD_HI:   res.read_byte = {4'b0, rdata_r[7:4]};
      gvam_pkg::OP_RD_LO:   res.read_byte = {4'b0, rdata_r[3:0]};
      gvam_pkg::OP_WR_NONE: res.dirty_valid = 1'b1;
      gvam_pkg::OP_WR_BYTE: begin
        res.dirty_valid = 1'b1;
        store           = 1'b1;
        merged          = ex_r.wdata;
      end
      gvam_pkg::OP_WR_HI: begin
        res.dirty_valid = 1'b1;
        store           = 1'b1;
        merged          = {ex_r.wdata[3:0], rdata_r[3:0]};
      end
      gvam_pkg::OP_WR_LO: begin
        res.dirty_valid = 1'b1;
        store           = 1'b1;
        merged          = {rdata_r[7:4], ex_r.wdata[3:0]};
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    if (state_r == BK_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = finish && store;
      mem_waddr = ex_r.idx;
      mem_wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata_r <= mem[head.idx];
      ex_r    <= head;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (&clr_idx_r) state_nxt = BK_IDLE;
      BK_IDLE:  if (pop)        state_nxt = BK_EXEC;
      BK_EXEC:  if (finish)     state_nxt = BK_IDLE;
      default:                  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= res;
    end
  end

  assign stat.clearing = state_r == BK_CLEAR;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

[src/graphic_vram_access_mapper.sv]
// ----------------------------------------------------------------------------
// graphic_vram_access_mapper: byte bus access to a 512 KB graphics memory
// Maps bus reads and writes by colour mode and reports dirty screen lines.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------
//   in_      | input     | in_valid / in_stall  | gvam_pkg::in_t  (30 bits)
//   out_     | output    | out_valid / out_stall| gvam_pkg::out_t (29 bits)
//   config   | input     | psel/penable/pready | 5 regs at 4*i, 32-bit data
//
// In the memory engine each word is first read: the pixel byte at its
// mapped index is registered as the word leaves the queue. It is then
// merged, written back and loaded into the result register once that
// register is free. After reset the store is cleared one byte a cycle,
// a pass during which in_stall stays high; configuration writes are
// taken throughout. A two-entry queue lets the bus side keep handing in
// words while a stalled result waits on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module graphic_vram_access_mapper (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gvam_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gvam_pkg::PDATA_W-1:0] pwdata,
  output logic      [gvam_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire gvam_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output gvam_pkg::out_t                    out_data
);

  // The front end owns the registers and classifies each word into a
  // memory index, an operation and its dirty line numbers.
  gvam_pkg::q_status_t  q_stat;
  gvam_pkg::bk_status_t bk_stat;
  gvam_pkg::entry_t     push_entry;
  gvam_pkg::entry_t     head;
  logic                 push;
  logic                 pop;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  gvam_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .bk_stat  (bk_stat),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  // Classified words wait here until the memory engine is free.
  gvam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // The back end performs the read-modify-write and holds the result
  // until the receiver takes it.
  gvam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .stat      (bk_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/gvam_checker.sv]
// ----------------------------------------------------------------------------
// gvam_checker: port-level assertions for the access mapper
// Watches reset behavior, result holding and dirty report consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module gvam_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           pready,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire gvam_pkg::out_t out_data
);

  // Reset starts the clearing pass, so no word can be taken right after.
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A read result carries no dirty report at all.
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dirty_valid |->
      out_data.dirty_line == '0 && !out_data.extra_dirty_valid &&
      out_data.extra_dirty_line == '0)
    else $error("read result with dirty report");

  // An extra line only comes with a storing 256-colour write, whose
  // primary line is a nine-bit page line.
  a_extra_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.extra_dirty_valid |->
      out_data.dirty_valid && !out_data.dirty_line[9] && pready)
    else $error("extra dirty line without matching write");

endmodule

bind graphic_vram_access_mapper gvam_checker u_gvam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .pready    (pready),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
